/* hw/rtl/tisp_pkg.sv */
// ---------------------------------------------------------------------------
// Telnet IAC stream parser package
// Shared types, byte codes, register indexes and classification functions.
// ---------------------------------------------------------------------------
package tisp_pkg;

  // Telnet byte codes
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DOT  = 8'h2E;

  // Preview limit ceiling and register reset values
  localparam logic [6:0] PREVIEW_MAX        = 7'd64;
  localparam logic [6:0] PREVIEW_LIMIT_RST  = 7'd64;
  localparam logic [7:0] SHOWN_LIMIT_RST    = 8'd6;
  localparam logic [15:0] NEG_COUNT_MAX     = 16'hFFFF;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PREVIEW_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_LIMIT   = 8'd1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [2:0] {
    PH_DATA    = 3'd0,
    PH_IAC     = 3'd1,
    PH_VERB    = 3'd2,
    PH_SUB     = 3'd3,
    PH_SUB_IAC = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PREVIEW = 2'd1,
    EV_NEG     = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    RK_PREVIEW = 2'd0,
    RK_NEG     = 2'd1,
    RK_SUMMARY = 2'd2
  } res_kind_t;

  // Classified byte handed from the front end to the back end.
  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data_char;
    logic [1:0] verb;
    logic [7:0] option;
    logic       known;
    logic       last;
  } ev_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  data_char;
    logic [1:0]  verb_code;
    logic [7:0]  option_code;
    logic        option_known;
    logic [15:0] item_index;
    logic        shown;
    logic [15:0] negotiation_total;
    logic [6:0]  preview_total;
    logic        last_result;
  } res_t;

  function automatic logic [7:0] show_char(input logic [7:0] b);
    logic keep;
    keep = (b >= 8'h20 && b <= 8'h7E) || b == 8'h0D || b == 8'h0A || b == 8'h09;
    return keep ? b : B_DOT;
  endfunction

  function automatic logic opt_known(input logic [7:0] o);
    return o == 8'd0 || o == 8'd1 || o == 8'd3 || o == 8'd24 || o == 8'd31 ||
           o == 8'd32 || o == 8'd33 || o == 8'd34 || o == 8'd36;
  endfunction

endpackage

/* hw/rtl/telnet_iac_stream_parser_top.sv */
// A byte's result is registered in the event queue, then in the back end output
// register. Throughput: one byte per cycle while the queue is not full; a final
// byte that also yields a preview or negotiation result holds the queue head for
// its summary (single back end output register). A 4-entry queue absorbs these.
// Reset (synchronous, active low) clears the parser, queue and counters and
// restores the preview limit to 64 and the shown limit to 6.
// ---------------------------------------------------------------------------
// Telnet IAC stream parser top level
// Front end parser, event queue and result back end with a config port.
// ---------------------------------------------------------------------------
module telnet_iac_stream_parser_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] payload_byte
  input  logic [tisp_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] data_char, [9:8] verb_code, [17:10] option_code, [18] option_known,
  // [34:19] item_index, [35] shown, [51:36] negotiation_total,
  // [58:52] preview_total, [63:59] zero
  output logic [tisp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] result_kind
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tisp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tisp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tisp_pkg::*;

  ev_t  push_ev, head_ev;
  logic ev_push, ev_pop, q_full, q_not_empty;
  res_t res;

  assign cfg_ready = 1'b1;

  tisp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .ev_push  (ev_push),
    .ev       (push_ev)
  );

  tisp_fifo #(
    .WIDTH ($bits(ev_t)),
    .DEPTH (4)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .wdata     (push_ev),
    .pop       (ev_pop),
    .rdata     (head_ev),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  tisp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (q_not_empty),
    .ev        (head_ev),
    .ev_pop    (ev_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last_result;
  assign out_tdata = {5'd0, res.preview_total, res.negotiation_total, res.shown,
                      res.item_index, res.option_known, res.option_code,
                      res.verb_code, res.data_char};

endmodule

/* hw/rtl/tisp_front.sv */
// ---------------------------------------------------------------------------
// Telnet IAC parser front end
// Walks the IAC sequences byte by byte and turns each byte into an event.
// ---------------------------------------------------------------------------
module tisp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [7:0]              in_byte,
  input  logic                    in_last,
  input  logic                    q_full,
  output logic                    in_ready,
  output logic                    ev_push,
  output tisp_pkg::ev_t           ev
);
  import tisp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] held_verb_r, held_verb_nxt;
  logic       accept;
  logic       is_verb;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_verb  = in_byte >= B_WILL && in_byte <= B_DONT;

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    held_verb_nxt = held_verb_r;
    unique case (phase_r)
      PH_DATA: begin
        if (in_byte == B_IAC && !in_last) phase_nxt = PH_IAC;
      end
      PH_IAC: begin
        phase_nxt = PH_DATA;
        if (is_verb) begin
          if (!in_last) begin
            held_verb_nxt = 2'(in_byte - B_WILL);
            phase_nxt     = PH_VERB;
          end
        end else if (in_byte == B_SB) begin
          phase_nxt = PH_SUB;
        end
      end
      PH_VERB: phase_nxt = PH_DATA;
      PH_SUB: begin
        if (in_byte == B_IAC) phase_nxt = PH_SUB_IAC;
      end
      PH_SUB_IAC: begin
        if (in_byte == B_SE) phase_nxt = PH_DATA;
        else if (in_byte != B_IAC) phase_nxt = PH_SUB;
      end
      default: phase_nxt = PH_DATA;
    endcase
    // The final byte of a payload returns the parser to its idle state.
    if (in_last) begin
      phase_nxt     = PH_DATA;
      held_verb_nxt = 2'd0;
    end
  end

  // Event classification
  always_comb begin
    ev           = '0;
    ev.kind      = EV_NONE;
    ev.last      = in_last;
    unique case (phase_r)
      PH_DATA: begin
        if (!(in_byte == B_IAC && !in_last)) begin
          ev.kind      = EV_PREVIEW;
          ev.data_char = show_char(in_byte);
        end
      end
      PH_IAC: begin
        if (in_byte == B_IAC) begin
          ev.kind      = EV_PREVIEW;
          ev.data_char = B_IAC;
        end
      end
      PH_VERB: begin
        ev.kind   = EV_NEG;
        ev.verb   = held_verb_r;
        ev.option = in_byte;
        ev.known  = opt_known(in_byte);
      end
      PH_SUB, PH_SUB_IAC: ev.kind = EV_NONE;
      default: ev.kind = EV_NONE;
    endcase
  end

  // Bytes that lead to no result and do not end the payload stay here.
  assign ev_push = accept && (ev.kind != EV_NONE || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      held_verb_r <= 2'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      held_verb_r <= held_verb_nxt;
    end
  end

endmodule

/* hw/rtl/tisp_fifo.sv */
// ---------------------------------------------------------------------------
// Telnet IAC parser event queue
// Small register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module tisp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty,
  output logic             full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign not_empty = count_r != '0;
  assign full      = count_r == CW'(DEPTH);
  assign rdata     = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

/* hw/rtl/tisp_back.sv */
// ---------------------------------------------------------------------------
// Telnet IAC parser back end
// Keeps the per-payload counters and the registers, and issues the results.
// ---------------------------------------------------------------------------
module tisp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ev_valid,
  input  tisp_pkg::ev_t                     ev,
  output logic                              ev_pop,
  input  logic                              cfg_valid,
  input  logic [tisp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tisp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output tisp_pkg::res_t                    res
);
  import tisp_pkg::*;

  logic [6:0]  prev_lim_r;
  logic [7:0]  shown_lim_r;
  logic [6:0]  prev_cnt_r, prev_cnt_nxt;
  logic [15:0] neg_cnt_r, neg_cnt_nxt;
  logic        sum_pend_r, sum_pend_nxt;
  logic        out_valid_r;
  res_t        res_r, res_nxt;
  logic        load;
  logic        out_free;
  logic [6:0]  lim;
  logic        room;

  assign out_free  = !out_valid_r || res_ready;
  assign lim       = (prev_lim_r > PREVIEW_MAX) ? PREVIEW_MAX : prev_lim_r;
  assign room      = prev_cnt_r < lim;
  assign res_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    load         = 1'b0;
    ev_pop       = 1'b0;
    sum_pend_nxt = sum_pend_r;
    prev_cnt_nxt = prev_cnt_r;
    neg_cnt_nxt  = neg_cnt_r;
    res_nxt      = '0;
    res_nxt.kind = RK_SUMMARY;
    res_nxt.negotiation_total = neg_cnt_r;
    res_nxt.preview_total     = prev_cnt_r;
    res_nxt.last_result       = 1'b1;
    if (ev_valid) begin
      priority if (sum_pend_r || (ev.last && !(ev.kind == EV_NEG) &&
                                  !(ev.kind == EV_PREVIEW && room))) begin
        // Summary closes the payload and clears the counters.
        if (out_free) begin
          load         = 1'b1;
          ev_pop       = 1'b1;
          sum_pend_nxt = 1'b0;
          prev_cnt_nxt = '0;
          neg_cnt_nxt  = '0;
        end
      end else if (ev.kind == EV_NEG) begin
        if (out_free) begin
          load                 = 1'b1;
          res_nxt              = '0;
          res_nxt.kind         = RK_NEG;
          res_nxt.verb_code    = ev.verb;
          res_nxt.option_code  = ev.option;
          res_nxt.option_known = ev.known;
          res_nxt.item_index   = neg_cnt_r;
          res_nxt.shown        = neg_cnt_r < {8'd0, shown_lim_r};
          res_nxt.last_result  = !ev.last;
          if (neg_cnt_r != NEG_COUNT_MAX) neg_cnt_nxt = neg_cnt_r + 16'd1;
          if (ev.last) sum_pend_nxt = 1'b1;
          else ev_pop = 1'b1;
        end
      end else if (ev.kind == EV_PREVIEW && room) begin
        if (out_free) begin
          load                = 1'b1;
          res_nxt             = '0;
          res_nxt.kind        = RK_PREVIEW;
          res_nxt.data_char   = ev.data_char;
          res_nxt.item_index  = {9'd0, prev_cnt_r};
          res_nxt.last_result = !ev.last;
          prev_cnt_nxt        = prev_cnt_r + 7'd1;
          if (ev.last) sum_pend_nxt = 1'b1;
          else ev_pop = 1'b1;
        end
      end else begin
        // Preview full: the byte is dropped without a result.
        ev_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_pend_r  <= 1'b0;
      prev_cnt_r  <= '0;
      neg_cnt_r   <= '0;
      prev_lim_r  <= PREVIEW_LIMIT_RST;
      shown_lim_r <= SHOWN_LIMIT_RST;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (res_ready) out_valid_r <= 1'b0;
      sum_pend_r <= sum_pend_nxt;
      prev_cnt_r <= prev_cnt_nxt;
      neg_cnt_r  <= neg_cnt_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_PREVIEW_LIMIT) prev_lim_r <= cfg_data[6:0];
        else if (cfg_index == CFG_SHOWN_LIMIT) shown_lim_r <= cfg_data[7:0];
      end
    end
  end

endmodule

/* hw/rtl/tisp_checker.sv */
// ---------------------------------------------------------------------------
// Telnet IAC parser port checker
// Watches the top level ports for result framing and handshake slips.
// ---------------------------------------------------------------------------
module tisp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import tisp_pkg::*;

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  // Reset empties the output stage.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A summary is always the final result for its byte.
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == RK_SUMMARY |-> out_tlast)
    else $error("summary not marked last");

  // Preview and negotiation results carry no summary totals.
  a_no_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RK_PREVIEW || out_tuser == RK_NEG)
      |-> out_tdata[58:36] == 23'd0)
    else $error("totals set on a non-summary result");

endmodule

bind telnet_iac_stream_parser_top tisp_checker u_tisp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
